### sv/bctg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bctg_pkg
// Shared types and constants of the Bernoulli cell traffic generator.
// ----------------------------------------------------------------------------
package bctg_pkg;

	localparam int PROB_BITS       = 16;
	localparam int VAL_W           = PROB_BITS + 1;
	localparam int LCG_W           = 48;
	localparam int LCG_NUM         = 3;
	localparam int DEF_MAX_OUTPUTS = 16;
	localparam int DEF_MAX_PRIOS   = 8;

	localparam int REQ_W    = 2;
	localparam int IDX_W    = 4;
	localparam int DEST_W   = 4;
	localparam int PRIO_W   = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;
	localparam int S_TDATA_W  = 24;
	localparam int M_TDATA_W  = 8;

	localparam logic [23:0] LCG_MUL_LO = 24'hECE66D;
	localparam logic [10:0] LCG_MUL_HI = 11'h5DE;
	localparam logic [3:0]  LCG_ADD    = 4'hB;

	localparam logic [VAL_W-1:0] RST_TOTAL_UTIL = 17'd32768;
	localparam logic [VAL_W-1:0] RST_MCAST      = 17'd0;
	localparam logic [VAL_W-1:0] RST_PRIO_TOTAL = 17'd32768;
	localparam logic [3:0]       RST_LEVELS     = 4'd1;
	localparam logic [4:0]       RST_OUTPUTS    = 5'd16;
	localparam logic [LCG_W-1:0] RST_ARR_SEED   = 48'd72038925537844;
	localparam logic [LCG_W-1:0] RST_CAST_SEED  = 48'd183853073540449;
	localparam logic [LCG_W-1:0] RST_PRIO_SEED  = 48'd68695818912386;

	typedef enum logic [REQ_W-1:0] {
		REQ_TICK      = 2'd0,
		REQ_WR_THRESH = 2'd1,
		REQ_WR_UCAST  = 2'd2,
		REQ_WR_MCAST  = 2'd3
	} req_type_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TOTAL_UTIL  = 3'd0,
		REG_MCAST_FRAC  = 3'd1,
		REG_PRIO_TOTAL  = 3'd2,
		REG_PRIO_LEVELS = 3'd3,
		REG_OUTPUT_CNT  = 3'd4,
		REG_ARR_SEED    = 3'd5,
		REG_CAST_SEED   = 3'd6,
		REG_PRIO_SEED   = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		LCG_ARRIVAL = 2'd0,
		LCG_CAST    = 2'd1,
		LCG_PRIO    = 2'd2
	} lcg_sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LCG_MUL,
		ST_LCG_SUM,
		ST_LCG_WB,
		ST_DEST,
		ST_PWALK,
		ST_OUT
	} fsm_state_t;

	typedef struct packed {
		logic             en;
		lcg_sel_t         sel;
		logic [LCG_W-1:0] data;
	} lcg_wr_t;

endpackage : bctg_pkg
`default_nettype wire

### sv/bctg_lcg_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bctg_lcg_step
// Two-stage 48-bit LCG update, x' = (0x5DEECE66D * x + 0xB) mod 2^48, built
// from three narrow partial products registered before the final sum.
// ----------------------------------------------------------------------------
module bctg_lcg_step (
	input  wire logic                      clk,
	input  wire logic [bctg_pkg::LCG_W-1:0] state,
	output logic      [bctg_pkg::LCG_W-1:0] next_state
);
	import bctg_pkg::*;

	localparam int HALF = LCG_W / 2;

	logic [HALF-1:0]  x_lo;
	logic [HALF-1:0]  x_hi;
	logic [LCG_W-1:0] p_ll;
	logic [LCG_W-1:0] p_lh;
	logic [LCG_W-1:0] p_hl;
	logic [LCG_W-1:0] p_ll_s1;
	logic [HALF-1:0]  p_lh_s1;
	logic [HALF-1:0]  p_hl_s1;
	logic [HALF-1:0]  mid;

	assign x_lo = state[HALF-1:0];
	assign x_hi = state[LCG_W-1:HALF];
	assign p_ll = LCG_W'(x_lo) * LCG_W'(LCG_MUL_LO);
	assign p_lh = LCG_W'(x_hi) * LCG_W'(LCG_MUL_LO);
	assign p_hl = LCG_W'(x_lo) * LCG_W'(LCG_MUL_HI);
	assign mid  = p_lh_s1 + p_hl_s1;

	always_ff @(posedge clk) begin
		p_ll_s1    <= p_ll;
		p_lh_s1    <= p_lh[HALF-1:0];
		p_hl_s1    <= p_hl[HALF-1:0];
		next_state <= p_ll_s1 + {mid, {HALF{1'b0}}} + LCG_W'(LCG_ADD);
	end

endmodule : bctg_lcg_step
`default_nettype wire

### sv/bctg_lcg_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bctg_lcg_ram
// Generator state memory with one entry per LCG and a registered read. An
// entry that has not been written since reset or a seed load reads as its seed.
// ----------------------------------------------------------------------------
module bctg_lcg_ram (
	input  wire logic                                          clk,
	input  wire logic                                          arst_n,
	input  wire bctg_pkg::lcg_sel_t                            rd_sel,
	input  wire bctg_pkg::lcg_wr_t                             wr,
	input  wire logic [bctg_pkg::LCG_NUM-1:0]                  inval,
	input  wire logic [bctg_pkg::LCG_NUM-1:0][bctg_pkg::LCG_W-1:0] seeds,
	output logic      [bctg_pkg::LCG_W-1:0]                    rd_data
);
	import bctg_pkg::*;

	logic [LCG_W-1:0]   mem [LCG_NUM];
	logic [LCG_NUM-1:0] valid_q;
	logic [LCG_W-1:0]   rd_mem_q;
	logic               rd_valid_q;
	lcg_sel_t           rd_sel_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.sel] <= wr.data;
		end
		rd_mem_q <= mem[rd_sel];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
			rd_sel_q   <= LCG_ARRIVAL;
		end else begin
			for (int i = 0; i < LCG_NUM; i++) begin
				if (inval[i]) begin
					valid_q[i] <= 1'b0;
				end else if (wr.en && (int'(wr.sel) == i)) begin
					valid_q[i] <= 1'b1;
				end
			end
			rd_valid_q <= valid_q[rd_sel];
			rd_sel_q   <= rd_sel;
		end
	end

	assign rd_data = rd_valid_q ? rd_mem_q : seeds[rd_sel_q];

endmodule : bctg_lcg_ram
`default_nettype wire

### sv/bctg_tbl_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bctg_tbl_ram
// Table memory holding the output thresholds followed by the unicast and
// multicast priority weights, one write port and one registered read port.
// ----------------------------------------------------------------------------
module bctg_tbl_ram #(
	parameter int DEPTH = bctg_pkg::DEF_MAX_OUTPUTS + 2 * bctg_pkg::DEF_MAX_PRIOS,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic [AW-1:0]                 waddr,
	input  wire logic [bctg_pkg::VAL_W-1:0]    wdata,
	input  wire logic [AW-1:0]                 raddr,
	output logic      [bctg_pkg::VAL_W-1:0]    rdata
);
	import bctg_pkg::*;

	logic [VAL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule : bctg_tbl_ram
`default_nettype wire

### sv/bernoulli_cell_traffic_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bernoulli_cell_traffic_generator
// Per-slot cell arrival generator: three LCG draws decide arrival, multicast
// and priority, and a threshold table walk picks the destination output.
//
// Channel  Direction  Contents
// s_*      in         tuser: req_type; tdata: entry_index, entry_value
// m_*      out        tuser: is_multicast; tdata: cell_valid, dest_output,
//                     cell_priority
// cfg_*    in         register write: index and data, no read-back
//
// A write item is taken in the idle state. A tick without a cell is only
// the read, multiply and write-back of the arrival LCG.
// A tick with a cell adds a threshold walk and a weight walk, with
// one table read per threshold and per weight visited, and two more LCG
// updates through the same state memory. Items are taken one at a time.
// A finished cell waits in the output register; while that register is full,
// the next cell is held in the final state and no item is accepted until the
// register drains. Reset is asynchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module bernoulli_cell_traffic_generator #(
	parameter int MAX_OUTPUTS    = bctg_pkg::DEF_MAX_OUTPUTS,
	parameter int MAX_PRIORITIES = bctg_pkg::DEF_MAX_PRIOS
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// [3:0] entry_index, [20:4] entry_value, [23:21] zero
	input  wire logic [bctg_pkg::S_TDATA_W-1:0]     s_tdata,
	// [1:0] req_type
	input  wire logic [bctg_pkg::REQ_W-1:0]         s_tuser,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// [0] cell_valid, [4:1] dest_output, [7:5] cell_priority
	output logic      [bctg_pkg::M_TDATA_W-1:0]     m_tdata,
	// [0] is_multicast
	output logic                                    m_tuser,
	input  wire logic                               cfg_we,
	input  wire logic [bctg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [bctg_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import bctg_pkg::*;

	localparam int TBL_DEPTH = MAX_OUTPUTS + 2 * MAX_PRIORITIES;
	localparam int TBL_AW    = $clog2(TBL_DEPTH);
	localparam int OIW       = $clog2(MAX_OUTPUTS);
	localparam int PIW       = (MAX_PRIORITIES > 1) ? $clog2(MAX_PRIORITIES) : 1;
	localparam int SCL_W     = PROB_BITS + VAL_W;
	localparam int TOT_W     = SCL_W + $clog2(MAX_PRIORITIES + 1) + 2;
	localparam int UC_BASE   = MAX_OUTPUTS;
	localparam int MC_BASE   = MAX_OUTPUTS + MAX_PRIORITIES;

	// Configuration registers.
	logic [VAL_W-1:0] total_util_q;
	logic [VAL_W-1:0] mcast_q;
	logic [VAL_W-1:0] prio_total_q;
	logic [3:0]       levels_q;
	logic [4:0]       outs_q;
	logic [LCG_NUM-1:0][LCG_W-1:0] seeds_q;
	logic [LCG_NUM-1:0] lcg_inval;

	// Control and datapath.
	fsm_state_t state_q;
	fsm_state_t state_d;
	lcg_sel_t   lcg_sel_q;
	lcg_sel_t   st_rd_sel;
	lcg_wr_t    lcg_wr;
	logic [LCG_W-1:0] lcg_rd_data;
	logic [LCG_W-1:0] lcg_next;
	logic [PROB_BITS-1:0] draw;
	logic [PROB_BITS-1:0] arr_draw_q;
	logic [OIW-1:0]   dest_q;
	logic [PIW-1:0]   pidx_q;
	logic [PIW-1:0]   pidx_start;
	logic             mc_q;
	logic [SCL_W-1:0] scaled_q;
	logic signed [TOT_W-1:0] total_q;
	logic signed [TOT_W-1:0] total_new;
	logic signed [TOT_W-1:0] scaled_ext;

	logic              tbl_we;
	logic [TBL_AW-1:0] tbl_waddr;
	logic [TBL_AW-1:0] tbl_raddr;
	logic [VAL_W-1:0]  tbl_rdata;
	logic [TBL_AW-1:0] w_base;

	req_type_t        in_req;
	logic [IDX_W-1:0] in_idx;
	logic [VAL_W-1:0] in_val;
	logic             in_range;
	logic             tick_acc;

	int               outs_c;
	int               levels_c;
	logic             arr_hit;
	logic             dest_done;
	logic             prio_hit;
	logic             load_out;

	logic             m_tvalid_q;
	logic             out_mc_q;
	logic [DEST_W-1:0] out_dest_q;
	logic [PRIO_W-1:0] out_prio_q;
	logic [PRIO_W-1:0] prio_q;

	assign in_req = req_type_t'(s_tuser);
	assign in_idx = s_tdata[IDX_W-1:0];
	assign in_val = s_tdata[IDX_W +: VAL_W];

	always_comb begin
		case (in_req)
			REQ_WR_THRESH: in_range = int'(in_idx) < MAX_OUTPUTS;
			REQ_WR_UCAST:  in_range = int'(in_idx) < MAX_PRIORITIES;
			REQ_WR_MCAST:  in_range = int'(in_idx) < MAX_PRIORITIES;
			default:       in_range = 1'b0;
		endcase
	end

	always_comb begin
		case (in_req)
			REQ_WR_UCAST: tbl_waddr = TBL_AW'(UC_BASE) + TBL_AW'(in_idx);
			REQ_WR_MCAST: tbl_waddr = TBL_AW'(MC_BASE) + TBL_AW'(in_idx);
			default:      tbl_waddr = TBL_AW'(in_idx);
		endcase
	end

	always_comb begin
		if (outs_q == 5'd0) begin
			outs_c = 1;
		end else if (int'(outs_q) > MAX_OUTPUTS) begin
			outs_c = MAX_OUTPUTS;
		end else begin
			outs_c = int'(outs_q);
		end
		if (levels_q == 4'd0) begin
			levels_c = 1;
		end else if (int'(levels_q) > MAX_PRIORITIES) begin
			levels_c = MAX_PRIORITIES;
		end else begin
			levels_c = int'(levels_q);
		end
	end

	assign pidx_start = PIW'(levels_c - 1);
	assign w_base     = mc_q ? TBL_AW'(MC_BASE) : TBL_AW'(UC_BASE);
	assign draw       = lcg_next[LCG_W-1 -: PROB_BITS];
	assign arr_hit    = {1'b0, draw} < total_util_q;
	assign dest_done  = (int'(dest_q) + 1 >= outs_c) || ({1'b0, arr_draw_q} < tbl_rdata);
	assign total_new  = total_q - $signed({{(TOT_W - VAL_W - PROB_BITS){1'b0}},
		tbl_rdata, {PROB_BITS{1'b0}}});
	assign scaled_ext = $signed({{(TOT_W - SCL_W){1'b0}}, scaled_q});
	assign prio_hit   = scaled_ext > total_new;
	assign tick_acc   = s_tvalid && s_tready && (in_req == REQ_TICK);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (tick_acc) begin
					state_d = ST_LCG_MUL;
				end
			end
			ST_LCG_MUL: state_d = ST_LCG_SUM;
			ST_LCG_SUM: state_d = ST_LCG_WB;
			ST_LCG_WB: begin
				case (lcg_sel_q)
					LCG_ARRIVAL: state_d = arr_hit ? ST_DEST : ST_IDLE;
					LCG_CAST:    state_d = ST_LCG_MUL;
					default:     state_d = ST_PWALK;
				endcase
			end
			ST_DEST: begin
				if (dest_done) begin
					state_d = ST_LCG_MUL;
				end
			end
			ST_PWALK: begin
				if (prio_hit || (pidx_q == '0)) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		s_tready  = 1'b0;
		tbl_we    = 1'b0;
		tbl_raddr = '0;
		st_rd_sel = LCG_ARRIVAL;
		lcg_wr    = '{en: 1'b0, sel: lcg_sel_q, data: lcg_next};
		load_out  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				tbl_we   = s_tvalid && in_range;
			end
			ST_LCG_WB: begin
				lcg_wr.en = 1'b1;
				if (lcg_sel_q == LCG_CAST) begin
					st_rd_sel = LCG_PRIO;
				end
				if (lcg_sel_q == LCG_PRIO) begin
					tbl_raddr = w_base + TBL_AW'(pidx_start);
				end
			end
			ST_DEST: begin
				tbl_raddr = TBL_AW'(dest_q) + TBL_AW'(1);
				st_rd_sel = LCG_CAST;
			end
			ST_PWALK: begin
				tbl_raddr = w_base + TBL_AW'(pidx_q) - TBL_AW'(1);
			end
			ST_OUT: begin
				load_out = !m_tvalid_q || m_tready;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			lcg_sel_q  <= LCG_ARRIVAL;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (tick_acc) begin
				lcg_sel_q <= LCG_ARRIVAL;
			end else if (state_q == ST_DEST && dest_done) begin
				lcg_sel_q <= LCG_CAST;
			end else if (state_q == ST_LCG_WB && lcg_sel_q == LCG_CAST) begin
				lcg_sel_q <= LCG_PRIO;
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LCG_WB) begin
			case (lcg_sel_q)
				LCG_ARRIVAL: begin
					arr_draw_q <= draw;
					dest_q     <= '0;
				end
				LCG_CAST: mc_q <= {1'b0, draw} < mcast_q;
				default: begin
					scaled_q <= SCL_W'(draw) * SCL_W'(prio_total_q);
					total_q  <= $signed({{(TOT_W - VAL_W - PROB_BITS){1'b0}},
						prio_total_q, {PROB_BITS{1'b0}}});
					pidx_q   <= pidx_start;
				end
			endcase
		end
		if (state_q == ST_DEST && !dest_done) begin
			dest_q <= dest_q + OIW'(1);
		end
		if (state_q == ST_PWALK && !prio_hit && (pidx_q != '0)) begin
			total_q <= total_new;
			pidx_q  <= pidx_q - PIW'(1);
		end
		if (state_q == ST_PWALK) begin
			prio_q <= prio_hit ? PRIO_W'(pidx_q) : '0;
		end
		if (load_out) begin
			out_mc_q   <= mc_q;
			out_dest_q <= DEST_W'(dest_q);
			out_prio_q <= prio_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_util_q <= RST_TOTAL_UTIL;
			mcast_q      <= RST_MCAST;
			prio_total_q <= RST_PRIO_TOTAL;
			levels_q     <= RST_LEVELS;
			outs_q       <= RST_OUTPUTS;
			seeds_q[LCG_ARRIVAL] <= RST_ARR_SEED;
			seeds_q[LCG_CAST]    <= RST_CAST_SEED;
			seeds_q[LCG_PRIO]    <= RST_PRIO_SEED;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_TOTAL_UTIL:  total_util_q <= cfg_wdata[VAL_W-1:0];
				REG_MCAST_FRAC:  mcast_q      <= cfg_wdata[VAL_W-1:0];
				REG_PRIO_TOTAL:  prio_total_q <= cfg_wdata[VAL_W-1:0];
				REG_PRIO_LEVELS: levels_q     <= cfg_wdata[3:0];
				REG_OUTPUT_CNT:  outs_q       <= cfg_wdata[4:0];
				REG_ARR_SEED:    seeds_q[LCG_ARRIVAL] <= cfg_wdata[LCG_W-1:0];
				REG_CAST_SEED:   seeds_q[LCG_CAST]    <= cfg_wdata[LCG_W-1:0];
				REG_PRIO_SEED:   seeds_q[LCG_PRIO]    <= cfg_wdata[LCG_W-1:0];
				default:         total_util_q <= total_util_q;
			endcase
		end
	end

	// A seed load makes the generator entry read back as the new seed.
	always_comb begin
		lcg_inval = '0;
		if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_ARR_SEED:  lcg_inval[LCG_ARRIVAL] = 1'b1;
				REG_CAST_SEED: lcg_inval[LCG_CAST]    = 1'b1;
				REG_PRIO_SEED: lcg_inval[LCG_PRIO]    = 1'b1;
				default:       lcg_inval = '0;
			endcase
		end
	end

	bctg_lcg_ram u_lcg_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_sel  (st_rd_sel),
		.wr      (lcg_wr),
		.inval   (lcg_inval),
		.seeds   (seeds_q),
		.rd_data (lcg_rd_data)
	);

	bctg_lcg_step u_lcg_step (
		.clk        (clk),
		.state      (lcg_rd_data),
		.next_state (lcg_next)
	);

	bctg_tbl_ram #(
		.DEPTH (TBL_DEPTH),
		.AW    (TBL_AW)
	) u_tbl_ram (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (in_val),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_mc_q;
	assign m_tdata  = {out_prio_q, out_dest_q, 1'b1};

`ifndef ASSERT_OFF
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!m_tvalid_q || m_tready))
		else $error("result register loaded while a result is still pending");

	a_tick_starts: assert property (@(posedge clk) disable iff (!arst_n)
		tick_acc |=> (state_q == ST_LCG_MUL && lcg_sel_q == LCG_ARRIVAL))
		else $error("accepted tick did not start the arrival draw");

	a_dest_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DEST) |-> (int'(dest_q) < outs_c))
		else $error("destination walk ran past the outputs in use");

	a_prio_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PWALK) |-> (int'(pidx_q) < levels_c))
		else $error("priority walk ran past the levels in use");
`endif

endmodule : bernoulli_cell_traffic_generator
`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Bernoulli cell traffic generator. A scoreboard
// class keeps its own copy of the three LCG states, the registers and the
// threshold and weight tables, works out the cell that every accepted tick
// produces, and compares each cell transaction on the master side with the
// oldest predicted cell. Stimulus starts with a directed pass over the table
// writes and the register extremes, then runs phases of random items under
// random register settings, with random gaps on both stream sides.
// ----------------------------------------------------------------------------
module tb_top;
	import bctg_pkg::*;

	localparam logic [47:0] RAND_MUL  = 48'h5DEECE66D;
	localparam logic [47:0] RAND_INC  = 48'hB;
	localparam int          N_PHASES  = 12;
	localparam int          PHASE_LEN = 118;
	localparam int          DRAIN     = 64;
	localparam longint      LIMIT     = 1000000;

	typedef struct packed {
		logic        mc;
		logic [3:0]  dest;
		logic [2:0]  prio;
	} cell_t;

	class cell_board;
		logic [16:0] util, mfrac, ptotal;
		logic [3:0]  levels;
		logic [4:0]  outs;
		logic [47:0] arr_st, cast_st, prio_st;
		logic [16:0] thresh[16];
		logic [16:0] uw[8];
		logic [16:0] mw[8];
		cell_t       pending_cells[$];
		int          errors;

		function new();
			util    = RST_TOTAL_UTIL;
			mfrac   = RST_MCAST;
			ptotal  = RST_PRIO_TOTAL;
			levels  = RST_LEVELS;
			outs    = RST_OUTPUTS;
			arr_st  = RST_ARR_SEED;
			cast_st = RST_CAST_SEED;
			prio_st = RST_PRIO_SEED;
			errors  = 0;
			foreach (thresh[i]) thresh[i] = '0;
			foreach (uw[i]) uw[i] = '0;
			foreach (mw[i]) mw[i] = '0;
		endfunction

		function void apply_reg(cfg_reg_t r, logic [47:0] v);
			case (r)
				REG_TOTAL_UTIL:  util = v[16:0];
				REG_MCAST_FRAC:  mfrac = v[16:0];
				REG_PRIO_TOTAL:  ptotal = v[16:0];
				REG_PRIO_LEVELS: levels = v[3:0];
				REG_OUTPUT_CNT:  outs = v[4:0];
				REG_ARR_SEED:    arr_st = v;
				REG_CAST_SEED:   cast_st = v;
				REG_PRIO_SEED:   prio_st = v;
				default: ;
			endcase
		endfunction

		function logic [15:0] advance(inout logic [47:0] st);
			st = RAND_MUL * st + RAND_INC;
			return st[47:32];
		endfunction

		function logic [2:0] walk_priority(logic mc);
			int          lv;
			int          p;
			bit          found;
			longint      scaled;
			longint      total;
			logic [16:0] w;
			logic [2:0]  res;
			lv = (levels == 0) ? 1 : ((levels > 8) ? 8 : int'(levels));
			scaled = longint'(advance(prio_st)) * longint'(ptotal);
			total = longint'(ptotal) << 16;
			res = '0;
			found = 0;
			for (p = lv - 1; p >= 0 && !found; p--) begin
				w = mc ? mw[p] : uw[p];
				total -= longint'(w) << 16;
				if (scaled > total) begin
					res = p[2:0];
					found = 1;
				end
			end
			return res;
		endfunction

		function void note_item(req_type_t req, logic [3:0] idx, logic [16:0] val);
			logic [15:0] d;
			int          n_out;
			int          dst;
			cell_t       c;
			case (req)
				REQ_WR_THRESH: thresh[idx] = val;
				REQ_WR_UCAST:  if (idx < 8) uw[idx[2:0]] = val;
				REQ_WR_MCAST:  if (idx < 8) mw[idx[2:0]] = val;
				default: begin
					d = advance(arr_st);
					if ({1'b0, d} < util) begin
						n_out = (outs == 0) ? 1 : ((outs > 16) ? 16 : int'(outs));
						dst = 0;
						while (dst + 1 < n_out && !({1'b0, d} < thresh[dst]))
							dst++;
						c.dest = dst[3:0];
						c.mc = {1'b0, advance(cast_st)} < mfrac;
						c.prio = walk_priority(c.mc);
						pending_cells.push_back(c);
					end
				end
			endcase
		endfunction

		task report(string msg);
			$display("MISMATCH @%0t: %s", $time, msg);
			errors++;
		endtask

		task check_cell(logic [7:0] data, logic mc);
			cell_t c;
			if (pending_cells.size() == 0) begin
				report($sformatf("cell with nothing pending: tdata=%h tuser=%b", data, mc));
			end else begin
				c = pending_cells.pop_front();
				if (data[0] !== 1'b1)
					report($sformatf("cell_valid %b", data[0]));
				if (mc !== c.mc)
					report($sformatf("is_multicast %b, want %b", mc, c.mc));
				if (data[4:1] !== c.dest)
					report($sformatf("dest_output %0d, want %0d", data[4:1], c.dest));
				if (data[7:5] !== c.prio)
					report($sformatf("cell_priority %0d, want %0d", data[7:5], c.prio));
			end
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata = '0;
	logic [REQ_W-1:0]      s_tuser = REQ_TICK;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  m_tuser;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_TOTAL_UTIL;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	cell_board sb = new();
	bit        steady = 0;
	int        rx_left = 0;
	longint    cycles = 0;

	bernoulli_cell_traffic_generator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("bernoulli_cell_traffic_generator verification failed");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(negedge clk) begin
		int hold;
		if (!arst_n || steady) begin
			m_tready = 1'b1;
		end else if (rx_left > 0) begin
			rx_left--;
		end else begin
			hold = gap_len();
			if (m_tready && hold > 0) begin
				m_tready = 1'b0;
				rx_left = hold - 1;
			end else begin
				m_tready = 1'b1;
				rx_left = $urandom_range(0, 20);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_cell(m_tdata, m_tuser);
	end

	task automatic send(req_type_t req, logic [3:0] idx, logic [16:0] val);
		int g;
		g = gap_len();
		repeat (g) begin
			@(negedge clk);
			s_tvalid = 1'b0;
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser = req;
		s_tdata = {3'b000, val, idx};
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_item(req, idx, val);
	endtask

	task automatic ticks(int n);
		repeat (n) send(REQ_TICK, 4'($urandom), 17'($urandom));
	endtask

	task automatic wait_idle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (sb.pending_cells.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t r, logic [47:0] v);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = r;
		cfg_wdata = v;
		sb.apply_reg(r, v);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic logic [16:0] prob_value(int lo);
		case ($urandom_range(0, 7))
			0: return 17'd0;
			1: return 17'd65536;
			2: return 17'h1FFFF;
			default: return 17'($urandom_range(lo, 65536));
		endcase
	endfunction

	function automatic logic [47:0] seed_value();
		logic [63:0] r;
		r = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: return 48'd0;
			1: return 48'hFFFF_FFFF_FFFF;
			default: return r[47:0];
		endcase
	endfunction

	function automatic bit coin();
		return $urandom_range(0, 3) != 0;
	endfunction

	initial begin
		bit          all;
		req_type_t   req;
		int          ph;
		logic [16:0] util_v;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Table load: every entry that a tick can read is written first.
		for (int i = 0; i < 16; i++)
			send(REQ_WR_THRESH, 4'(i), (i == 15) ? 17'h1FFFF : 17'((i + 1) * 4096));
		for (int i = 0; i < 8; i++) begin
			send(REQ_WR_UCAST, 4'(i), 17'(4096 * (i + 1)));
			send(REQ_WR_MCAST, 4'(i), 17'(8192));
		end
		// Weight writes with an index past the eight weights must be dropped.
		send(REQ_WR_UCAST, 4'd15, 17'h1FFFF);
		send(REQ_WR_MCAST, 4'd8, 17'h1FFFF);
		ticks(8);
		wait_idle();

		write_reg(REG_TOTAL_UTIL, 48'd65536);
		write_reg(REG_MCAST_FRAC, 48'd65536);
		write_reg(REG_PRIO_TOTAL, 48'd65536);
		write_reg(REG_PRIO_LEVELS, 48'd15);
		write_reg(REG_OUTPUT_CNT, 48'd31);
		ticks(6);
		wait_idle();

		write_reg(REG_TOTAL_UTIL, 48'h1FFFF);
		write_reg(REG_MCAST_FRAC, 48'd0);
		write_reg(REG_PRIO_TOTAL, 48'd0);
		write_reg(REG_PRIO_LEVELS, 48'd0);
		write_reg(REG_OUTPUT_CNT, 48'd0);
		write_reg(REG_ARR_SEED, 48'd0);
		ticks(4);
		wait_idle();

		write_reg(REG_TOTAL_UTIL, 48'd0);
		write_reg(REG_CAST_SEED, 48'hFFFF_FFFF_FFFF);
		write_reg(REG_PRIO_SEED, 48'd0);
		ticks(3);

		for (ph = 0; ph < N_PHASES; ph++) begin
			wait_idle();
			all = (ph == 0);
			steady = ($urandom_range(0, 3) == 0);
			util_v = prob_value(16384);
			if (all || coin() || util_v == 0)
				write_reg(REG_TOTAL_UTIL, {31'd0, (util_v == 0) ? 17'd49152 : util_v});
			if (all || coin())
				write_reg(REG_MCAST_FRAC, {31'd0, prob_value(0)});
			if (all || coin())
				write_reg(REG_PRIO_TOTAL, {31'd0, prob_value(0)});
			if (all || coin())
				write_reg(REG_PRIO_LEVELS, 48'($urandom_range(0, 15)));
			if (all || coin())
				write_reg(REG_OUTPUT_CNT, 48'($urandom_range(0, 31)));
			if (all || coin())
				write_reg(REG_ARR_SEED, seed_value());
			if (all || coin())
				write_reg(REG_CAST_SEED, seed_value());
			if (all || coin())
				write_reg(REG_PRIO_SEED, seed_value());
			repeat (PHASE_LEN) begin
				if ($urandom_range(0, 99) < 75)
					req = REQ_TICK;
				else
					req = req_type_t'($urandom_range(1, 3));
				send(req, 4'($urandom), 17'($urandom));
			end
		end

		steady = 0;
		wait_idle();
		if (sb.errors == 0)
			$display("bernoulli_cell_traffic_generator verification clean");
		else
			$display("bernoulli_cell_traffic_generator verification failed");
		$finish;
	end

endmodule

### sim.f
sv/bctg_pkg.sv
sv/bctg_lcg_step.sv
sv/bctg_lcg_ram.sv
sv/bctg_tbl_ram.sv
sv/bernoulli_cell_traffic_generator.sv
tb/sv/tb_top.sv
